FILE: sv/asre_pkg.sv
// ----------------------------------------------------------------------------
// asre_pkg
// Shared types and constants of the antenna scan rate estimator.
// ----------------------------------------------------------------------------
package asre_pkg;

   localparam int RATE_BITS     = 32;
   localparam int INTERVAL_BITS = 32;
   localparam int SCALE_BITS    = 28;

   // 256 (fraction bits) times 1e6 (microseconds per second)
   localparam logic [SCALE_BITS-1:0]    RATE_SCALE     = 28'd256000000;
   localparam logic [RATE_BITS-1:0]     RATE_MAX       = 32'hFFFF_FFFF;
   localparam logic [INTERVAL_BITS-1:0] INTERVAL_RESET = 32'd1000000;

   typedef enum logic [2:0] {
      LANE_IDLE,
      LANE_EVAL,
      LANE_MUL,
      LANE_DIV,
      LANE_SAT,
      LANE_DONE
   } lane_state_type;

   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic                 updated;
      logic [RATE_BITS-1:0] rate;
   } lane_status_type;

endpackage

FILE: sv/asre_lane.sv
// ----------------------------------------------------------------------------
// asre_lane
// One axis: reference state, interval check, scale multiply and a
// restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module asre_lane import asre_pkg::*; #(
   parameter int ANGLE_BITS = 16,
   parameter int TIME_BITS  = 48
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [ANGLE_BITS-1:0]    angle,
   input  logic [TIME_BITS-1:0]     stamp_us,
   input  logic                     trans,
   input  logic [INTERVAL_BITS-1:0] interval,
   input  logic                     ack,
   output lane_status_type          status
);

   localparam int NUM_BITS = ANGLE_BITS + SCALE_BITS;
   localparam int CNT_BITS = $clog2(NUM_BITS);
   localparam logic [ANGLE_BITS-1:0] HALF = ANGLE_BITS'(1) << (ANGLE_BITS - 1);

   lane_state_type state_ff, state_in;

   logic                  started_ff;
   logic [TIME_BITS-1:0]  ref_time_ff;
   logic [ANGLE_BITS-1:0] ref_angle_ff;
   logic [RATE_BITS-1:0]  rate_ff;
   logic                  updated_ff;
   logic [ANGLE_BITS-1:0] cur_angle_ff;
   logic [TIME_BITS-1:0]  cur_time_ff;
   logic                  cur_trans_ff;
   logic [ANGLE_BITS-1:0] mag_ff;
   logic [TIME_BITS-1:0]  dt_ff;
   logic [NUM_BITS-1:0]   num_ff;
   logic [TIME_BITS-1:0]  rem_ff;
   logic [CNT_BITS-1:0]   count_ff;

   logic [TIME_BITS-1:0]  dt;
   logic [ANGLE_BITS-1:0] diff;
   logic [ANGLE_BITS-1:0] mag;
   logic                  hold;
   logic [TIME_BITS:0]    shifted;
   logic                  ge;
   logic [TIME_BITS-1:0]  rem_in;
   logic [NUM_BITS-1:0]   num_in;
   logic [RATE_BITS-1:0]  sat_rate;

   always_comb begin
      dt       = cur_time_ff - ref_time_ff;
      diff     = cur_angle_ff - ref_angle_ff;
      // shorter way round; exactly half a turn stays half a turn
      mag      = (diff > HALF) ? (ANGLE_BITS'(0) - diff) : diff;
      hold     = (dt < TIME_BITS'(interval)) || (dt == '0);
      shifted  = {rem_ff, num_ff[NUM_BITS-1]};
      ge       = shifted >= {1'b0, dt_ff};
      rem_in   = ge ? TIME_BITS'(shifted - {1'b0, dt_ff}) : shifted[TIME_BITS-1:0];
      num_in   = {num_ff[NUM_BITS-2:0], ge};
      sat_rate = (|num_ff[NUM_BITS-1:RATE_BITS]) ? RATE_MAX : num_ff[RATE_BITS-1:0];
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         LANE_IDLE: if (start) state_in = LANE_EVAL;
         LANE_EVAL: begin
            if (!started_ff || cur_trans_ff || hold) state_in = LANE_DONE;
            else                                     state_in = LANE_MUL;
         end
         LANE_MUL:  state_in = LANE_DIV;
         LANE_DIV:  if (count_ff == '0) state_in = LANE_SAT;
         LANE_SAT:  state_in = LANE_DONE;
         LANE_DONE: if (ack) state_in = LANE_IDLE;
         default:   state_in = LANE_IDLE;
      endcase
   end

   always_comb begin
      status.busy    = (state_ff != LANE_IDLE);
      status.done    = (state_ff == LANE_DONE);
      status.updated = updated_ff;
      status.rate    = rate_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= LANE_IDLE;
         started_ff   <= 1'b0;
         ref_time_ff  <= '0;
         ref_angle_ff <= '0;
         rate_ff      <= '0;
         updated_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         unique case (state_ff)
            LANE_IDLE: begin
               if (start) begin
                  cur_angle_ff <= angle;
                  cur_time_ff  <= stamp_us;
                  cur_trans_ff <= trans;
               end
            end
            LANE_EVAL: begin
               updated_ff <= 1'b0;
               if (!started_ff) begin
                  started_ff   <= 1'b1;
                  rate_ff      <= '0;
                  ref_time_ff  <= cur_time_ff;
                  ref_angle_ff <= cur_angle_ff;
               end else if (cur_trans_ff) begin
                  ref_time_ff  <= cur_time_ff;
                  ref_angle_ff <= cur_angle_ff;
               end else if (!hold) begin
                  mag_ff <= mag;
                  dt_ff  <= dt;
               end
            end
            LANE_MUL: begin
               num_ff   <= NUM_BITS'(mag_ff) * NUM_BITS'(RATE_SCALE);
               rem_ff   <= '0;
               count_ff <= CNT_BITS'(NUM_BITS - 1);
            end
            LANE_DIV: begin
               num_ff   <= num_in;
               rem_ff   <= rem_in;
               count_ff <= count_ff - 1'b1;
            end
            LANE_SAT: begin
               rate_ff      <= sat_rate;
               ref_time_ff  <= cur_time_ff;
               ref_angle_ff <= cur_angle_ff;
               updated_ff   <= 1'b1;
            end
            LANE_DONE: ;
            default: ;
         endcase
      end
   end

endmodule

FILE: sv/asre_merge.sv
// ----------------------------------------------------------------------------
// asre_merge
// Join the two lane results into one item and hold it in the output register.
// ----------------------------------------------------------------------------
module asre_merge import asre_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  lane_status_type      az_status,
   input  lane_status_type      el_status,
   output logic                 ack,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [RATE_BITS-1:0] rsp_az_rate,
   output logic [RATE_BITS-1:0] rsp_el_rate,
   output logic                 rsp_az_updated,
   output logic                 rsp_el_updated
);

   logic                 valid_ff;
   logic [RATE_BITS-1:0] az_rate_ff, el_rate_ff;
   logic                 az_updated_ff, el_updated_ff;

   // load when both lanes are finished and the slot is free or draining
   assign ack = az_status.done && el_status.done && (!valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ack) begin
         valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ack) begin
         az_rate_ff    <= az_status.rate;
         el_rate_ff    <= el_status.rate;
         az_updated_ff <= az_status.updated;
         el_updated_ff <= el_status.updated;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_az_rate    = az_rate_ff;
   assign rsp_el_rate    = el_rate_ff;
   assign rsp_az_updated = az_updated_ff;
   assign rsp_el_updated = el_updated_ff;

endmodule

FILE: sv/antenna_scan_rate_estimator_core.sv
// ----------------------------------------------------------------------------
// antenna_scan_rate_estimator_core
// Azimuth and elevation scan rates from a stream of radar rays.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+----------------------------------
//  req     | in        | req_valid/stall    | az, el angle, time, transition
//  rsp     | out       | rsp_valid/stall    | az, el rate and updated flags
//  csr     | in        | csr_valid/ready    | rate_interval_us
//
//  An item that computes a rate passes the evaluate, multiply, divide and
//  saturate steps, the divider in each lane retiring one quotient bit per
//  cycle; an item that keeps or restarts the reference skips straight to done.
//  One item is in the lanes at a time; the next is taken while the finished
//  item waits in the output register.
//  Reset clears the reference state of both axes and loads the interval
//  with 1000000 us.
//  A stalled output holds the lanes in their done state until the slot frees.
// ----------------------------------------------------------------------------
module antenna_scan_rate_estimator_core import asre_pkg::*; #(
   parameter int ANGLE_BITS = 16,
   parameter int TIME_BITS  = 48
) (
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [ANGLE_BITS-1:0]    req_az_angle,
   input  logic [ANGLE_BITS-1:0]    req_el_angle,
   input  logic [TIME_BITS-1:0]     req_ray_time_us,
   input  logic                     req_in_transition,

   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [RATE_BITS-1:0]     rsp_az_rate,
   output logic [RATE_BITS-1:0]     rsp_el_rate,
   output logic                     rsp_az_updated,
   output logic                     rsp_el_updated,

   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [INTERVAL_BITS-1:0] csr_rate_interval_us
);

   logic [INTERVAL_BITS-1:0] interval_ff;
   lane_status_type          az_status, el_status;
   logic                     start;
   logic                     ack;

   // the register accepts a write in any cycle
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= INTERVAL_RESET;
      end else if (csr_valid && csr_ready) begin
         interval_ff <= csr_rate_interval_us;
      end
   end

   // hold off new items while either lane still owns the current one
   assign req_stall = az_status.busy || el_status.busy;
   assign start     = req_valid && !req_stall;

   asre_lane #(
      .ANGLE_BITS(ANGLE_BITS),
      .TIME_BITS (TIME_BITS)
   ) u_az_lane (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .angle   (req_az_angle),
      .stamp_us(req_ray_time_us),
      .trans   (req_in_transition),
      .interval(interval_ff),
      .ack     (ack),
      .status  (az_status)
   );

   asre_lane #(
      .ANGLE_BITS(ANGLE_BITS),
      .TIME_BITS (TIME_BITS)
   ) u_el_lane (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .angle   (req_el_angle),
      .stamp_us(req_ray_time_us),
      .trans   (req_in_transition),
      .interval(interval_ff),
      .ack     (ack),
      .status  (el_status)
   );

   // combine both axes into one result item
   asre_merge u_merge (
      .clock         (clock),
      .reset         (reset),
      .az_status     (az_status),
      .el_status     (el_status),
      .ack           (ack),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_az_rate   (rsp_az_rate),
      .rsp_el_rate   (rsp_el_rate),
      .rsp_az_updated(rsp_az_updated),
      .rsp_el_updated(rsp_el_updated)
   );

   // an accepted item occupies the lanes on the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> req_stall)
      else $error("lanes not busy after accepting an item");

   // the lanes run in lockstep from the same start
   a_lanes_together: assert property (@(posedge clock) disable iff (reset)
      start |=> (az_status.busy && el_status.busy))
      else $error("lane started alone");

   // a new result only appears after both lanes finished
   a_rsp_from_lanes: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(az_status.done && el_status.done))
      else $error("result without both lanes done");

   // a finished pair with a free slot moves out at once
   a_merge_takes: assert property (@(posedge clock) disable iff (reset)
      (az_status.done && el_status.done && !rsp_valid) |=> rsp_valid)
      else $error("finished lanes not merged into free slot");

endmodule
